>>> rtl/bpht_pkg.sv
// Package for the bucketed pointer hash table.
// Holds field widths, the key-to-bucket shift and the operation codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpht_pkg;

  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int FUNC_W    = 2;
  localparam int KEY_SHIFT = 8;
  localparam int HKEY_W    = KEY_W - KEY_SHIFT;
  localparam int HCNT_W    = $clog2(HKEY_W);

  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

endpackage

`default_nettype wire

>>> rtl/bucketed_pointer_hash_table.sv
// Top level of the bucketed pointer hash table: sequencer, bucket index unit,
// way compare and the key/value stores. Uses bpht_pkg and bpht_ram.
//
//  channel   handshake            payload
//  command   start / busy         func, key, write_value
//  result    done (1-cycle pulse) success, read_value
//
// Bucket index: plain mask of key>>8 when NUM_BUCKETS is a power of two;
// otherwise key>>8 mod NUM_BUCKETS by reciprocal multiply (ST_QUO) and
// multiply-subtract (ST_REM), each registered.
// Then ST_BASE forms the bucket base, ST_RD issues the first read, ST_SCAN
// compares one way per cycle (single RAM port), ST_WR writes insert/clear hits.
// Zero key or unused func: result in the next cycle, busy stays low.
// After rst, the key store is zeroed one entry a cycle, all NUM_BUCKETS*WAYS
// entries, with busy high. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module bucketed_pointer_hash_table #(
  parameter int NUM_BUCKETS = 256,
  parameter int WAYS        = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [bpht_pkg::FUNC_W-1:0] func,
  input  logic [bpht_pkg::KEY_W-1:0]  key,
  input  logic [bpht_pkg::VAL_W-1:0]  write_value,
  output logic                        done,
  output logic                        success,
  output logic [bpht_pkg::VAL_W-1:0]  read_value
);

  import bpht_pkg::*;

  localparam int DEPTH   = NUM_BUCKETS * WAYS;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int PW      = RW + 7;
  localparam bit NB_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
  localparam logic [WW-1:0] LAST_WAY  = WW'(WAYS - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam int RL      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 0;
  localparam int RS      = HKEY_W + RL;
  localparam int MW      = HKEY_W + 1;
  localparam int PRW     = HKEY_W + MW;
  localparam longint unsigned RM =
    ((64'd1 << RS) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);

  typedef enum logic [7:0] {
    ST_CLR  = 8'b00000001,
    ST_IDLE = 8'b00000010,
    ST_QUO  = 8'b00000100,
    ST_REM  = 8'b00001000,
    ST_BASE = 8'b00010000,
    ST_RD   = 8'b00100000,
    ST_SCAN = 8'b01000000,
    ST_WR   = 8'b10000000
  } state_t;

  state_t              state;
  logic [FUNC_W-1:0]   op_func;
  logic [KEY_W-1:0]    op_key;
  logic [VAL_W-1:0]    op_wval;
  logic [RW-1:0]       rem;
  logic [HKEY_W-1:0]   quo;
  logic [AW-1:0]       base;
  logic [WW-1:0]       cmp_way;
  logic [AW-1:0]       clr_addr;

  logic [HKEY_W-1:0]   hkey;
  logic [HKEY_W-1:0]   in_hkey_masked;
  logic [RW-1:0]       in_bucket;
  logic [PRW-1:0]      quo_prod;
  logic [HKEY_W-1:0]   quo_next;
  logic [HKEY_W-1:0]   quo_nb;
  logic [HKEY_W-1:0]   rem_full;
  logic                func_ok;

  logic [AW-1:0]       ram_addr;
  logic                key_we;
  logic                val_we;
  logic [KEY_W-1:0]    key_wdata;
  logic [VAL_W-1:0]    val_wdata;
  logic [KEY_W-1:0]    key_rdata;
  logic [VAL_W-1:0]    val_rdata;
  logic                key_match;
  logic                key_empty;
  logic                way_hit;

  assign busy = (state != ST_IDLE);

  assign hkey           = op_key[KEY_W-1:KEY_SHIFT];
  assign in_hkey_masked = key[KEY_W-1:KEY_SHIFT] & HKEY_W'(NUM_BUCKETS - 1);
  assign in_bucket      = in_hkey_masked[RW-1:0];
  assign func_ok        = func inside {FUNC_LOOKUP, FUNC_INSERT, FUNC_CLEAR};

  // floor(x / NUM_BUCKETS) = (x * RM) >> RS, exact for every 24-bit x
  assign quo_prod = PRW'(hkey) * PRW'(RM);
  assign quo_next = HKEY_W'(quo_prod >> RS);
  assign quo_nb   = quo * HKEY_W'(NUM_BUCKETS);
  assign rem_full = hkey - quo_nb;

  assign key_match = (key_rdata == op_key);
  assign key_empty = (key_rdata == '0);

  always_comb begin
    case (op_func)
      FUNC_LOOKUP: way_hit = key_match;
      FUNC_INSERT: way_hit = key_match || key_empty;
      FUNC_CLEAR:  way_hit = key_match;
      default:     way_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (state == ST_CLR) begin
      ram_addr = clr_addr;
    end else if ((state == ST_SCAN) && (cmp_way != LAST_WAY)) begin
      ram_addr = base + AW'(cmp_way + WW'(1));
    end else begin
      ram_addr = base + AW'(cmp_way);
    end
  end

  assign key_we    = (state == ST_CLR) || (state == ST_WR);
  assign val_we    = (state == ST_WR);
  assign key_wdata = ((state == ST_WR) && (op_func == FUNC_INSERT)) ? op_key : '0;
  assign val_wdata = (op_func == FUNC_INSERT) ? op_wval : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            op_func <= func;
            op_key  <= key;
            op_wval <= write_value;
            if ((key == '0) || !func_ok) begin
              done       <= 1'b1;
              success    <= 1'b0;
              read_value <= '0;
            end else if (NB_POW2) begin
              rem   <= in_bucket;
              state <= ST_BASE;
            end else begin
              state <= ST_QUO;
            end
          end
        end
        ST_QUO: begin
          quo   <= quo_next;
          state <= ST_REM;
        end
        ST_REM: begin
          rem   <= RW'(rem_full);
          state <= ST_BASE;
        end
        ST_BASE: begin
          base    <= AW'(PW'(rem) * PW'(WAYS));
          cmp_way <= '0;
          state   <= ST_RD;
        end
        ST_RD: begin
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (way_hit) begin
            if (op_func == FUNC_LOOKUP) begin
              done       <= 1'b1;
              success    <= 1'b1;
              read_value <= val_rdata;
              state      <= ST_IDLE;
            end else begin
              state <= ST_WR;
            end
          end else if (cmp_way == LAST_WAY) begin
            done       <= 1'b1;
            success    <= 1'b0;
            read_value <= '0;
            state      <= ST_IDLE;
          end else begin
            cmp_way <= cmp_way + WW'(1);
          end
        end
        ST_WR: begin
          done       <= 1'b1;
          success    <= 1'b1;
          read_value <= '0;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  bpht_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .addr  (ram_addr),
    .wdata (key_wdata),
    .rdata (key_rdata)
  );

  bpht_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .addr  (ram_addr),
    .wdata (val_wdata),
    .rdata (val_rdata)
  );

`ifndef SYNTHESIS
  a_rst_clears: assert property (@(posedge clk) rst |=> (state == ST_CLR))
    else $error("reset did not start the clear pass");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted transaction neither in progress nor finished");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result issued while sequencer still busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !success) |-> (read_value == '0))
    else $error("failed transaction returned nonzero value");

  a_write_success: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR) |=> (done && success))
    else $error("store write not reported as success");
`endif

endmodule

`default_nettype wire

>>> rtl/bpht_ram.sv
// Generic single-port RAM, read-first, registered read data.
// Used for the key and value stores. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> tb/bucketed_pointer_hash_table_tb.sv
// Self-checking testbench for bucketed_pointer_hash_table: a directed command table,
// then random lookup/insert/clear traffic on a few hot buckets, checked by an in-bench
// model of the key/value store. Depends on bpht_pkg and the RTL top level.
`timescale 1ns / 1ps

module bucketed_pointer_hash_table_tb;
  import bpht_pkg::*;

  localparam int NUM_BUCKETS = 256;
  localparam int WAYS        = 8;
  localparam int DEPTH       = NUM_BUCKETS * WAYS;
  localparam int RAND_ITEMS  = 1700;
  localparam int POOL_N      = 28;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_DIRECTED  = 24;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic              ok;
    logic [VAL_W-1:0]  rd;
  } outcome_t;

  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic [KEY_W-1:0]  k;
    logic [VAL_W-1:0]  v;
    logic              typed;
    logic              ok;
    logic [VAL_W-1:0]  rd;
  } cmd_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [FUNC_W-1:0] func = FUNC_LOOKUP;
  logic [KEY_W-1:0]  key = '0;
  logic [VAL_W-1:0]  write_value = '0;
  logic              done;
  logic              success;
  logic [VAL_W-1:0]  read_value;

  logic [KEY_W-1:0]  key_mem [DEPTH];
  logic [VAL_W-1:0]  val_mem [DEPTH];
  outcome_t          pending_results [$];
  logic [KEY_W-1:0]  key_pool [POOL_N];
  logic [7:0]        hot_bucket [3];
  int                err_count = 0;
  int                cycle_count = 0;

  cmd_row_t dir_rows [N_DIRECTED] = '{
    '{FUNC_LOOKUP, 32'h0000_0100, 32'h0,          1'b1, 1'b0, 32'h0},
    '{FUNC_LOOKUP, 32'h0000_0000, 32'h0,          1'b1, 1'b0, 32'h0},
    '{FUNC_INSERT, 32'h0000_0000, 32'hFFFF_FFFF,  1'b1, 1'b0, 32'h0},
    '{FUNC_CLEAR,  32'h0000_0000, 32'h0,          1'b1, 1'b0, 32'h0},
    '{FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF,  1'b1, 1'b0, 32'h0},
    '{FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF,  1'b1, 1'b1, 32'h0},
    '{FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0,          1'b1, 1'b1, 32'hFFFF_FFFF},
    '{FUNC_INSERT, 32'hFFFF_FFFF, 32'h0000_0000,  1'b1, 1'b1, 32'h0},
    '{FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0,          1'b1, 1'b1, 32'h0},
    '{FUNC_INSERT, 32'h0000_1201, 32'h1111_1111,  1'b0, 1'b0, 32'h0},
    '{FUNC_INSERT, 32'h8000_1200, 32'h2222_2222,  1'b0, 1'b0, 32'h0},
    '{FUNC_INSERT, 32'h0001_12FF, 32'h3333_3333,  1'b0, 1'b0, 32'h0},
    '{FUNC_INSERT, 32'hFFFF_1234, 32'h4444_4444,  1'b0, 1'b0, 32'h0},
    '{FUNC_INSERT, 32'h1234_1256, 32'h5555_5555,  1'b0, 1'b0, 32'h0},
    '{FUNC_INSERT, 32'h5555_12AA, 32'hAAAA_AAAA,  1'b0, 1'b0, 32'h0},
    '{FUNC_INSERT, 32'hAAAA_1255, 32'h0F0F_0F0F,  1'b0, 1'b0, 32'h0},
    '{FUNC_INSERT, 32'h7FFF_1280, 32'hF0F0_F0F0,  1'b0, 1'b0, 32'h0},
    '{FUNC_INSERT, 32'h0100_1201, 32'hDEAD_0001,  1'b1, 1'b0, 32'h0},
    '{FUNC_CLEAR,  32'h0001_12FF, 32'h0,          1'b0, 1'b0, 32'h0},
    '{FUNC_LOOKUP, 32'h7FFF_1280, 32'h0,          1'b0, 1'b0, 32'h0},
    '{FUNC_INSERT, 32'h0100_1201, 32'hDEAD_0001,  1'b0, 1'b0, 32'h0},
    '{FUNC_CLEAR,  32'h0001_12FF, 32'h0,          1'b1, 1'b0, 32'h0},
    '{FUNC_LOOKUP, 32'h0100_1201, 32'h0,          1'b0, 1'b0, 32'h0},
    '{FUNC_UNUSED, 32'h0000_0000, 32'h0,          1'b1, 1'b0, 32'h0}
  };

  bucketed_pointer_hash_table #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .WAYS       (WAYS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .key        (key),
    .write_value(write_value),
    .done       (done),
    .success    (success),
    .read_value (read_value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Scans the ways of the key's bucket and applies the operation to the model store.
  function automatic outcome_t table_access(input logic [FUNC_W-1:0] op,
                                            input logic [KEY_W-1:0] k,
                                            input logic [VAL_W-1:0] v);
    outcome_t r;
    int       base;
    int       idx;
    r = '0;
    base = ((k >> KEY_SHIFT) % NUM_BUCKETS) * WAYS;
    if (k != '0 && op != FUNC_UNUSED) begin
      for (int w = 0; w < WAYS; w++) begin
        idx = base + w;
        if (op == FUNC_LOOKUP && key_mem[idx] == k) begin
          r.ok = 1'b1;
          r.rd = val_mem[idx];
          break;
        end else if (op == FUNC_INSERT && (key_mem[idx] == k || key_mem[idx] == '0)) begin
          key_mem[idx] = k;
          val_mem[idx] = v;
          r.ok = 1'b1;
          break;
        end else if (op == FUNC_CLEAR && key_mem[idx] == k) begin
          key_mem[idx] = '0;
          val_mem[idx] = '0;
          r.ok = 1'b1;
          break;
        end
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic issue_cmd(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] k,
                           input logic [VAL_W-1:0] v, input logic typed,
                           input logic t_ok, input logic [VAL_W-1:0] t_rd,
                           input int idle_pct);
    outcome_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start       <= 1'b1;
    func        <= op;
    key         <= k;
    write_value <= v;
    do @(posedge clk); while (busy);
    r = table_access(op, k, v);
    if (typed) begin
      r.ok = t_ok;
      r.rd = t_rd;
    end
    pending_results.push_back(r);
  endtask

  function automatic logic [KEY_W-1:0] fresh_pool_key();
    logic [KEY_W-1:0] k;
    k = $urandom;
    k[15:8] = hot_bucket[$urandom_range(0, 2)];
    if (k == '0) begin
      k = 32'h0000_0001;
    end
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    int slot;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      return '0;
    end else if (r < 13) begin
      return $urandom;
    end
    slot = $urandom_range(0, POOL_N - 1);
    if ($urandom_range(0, 99) < 8) begin
      key_pool[slot] = fresh_pool_key();
    end
    return key_pool[slot];
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      return FUNC_LOOKUP;
    end else if (r < 72) begin
      return FUNC_INSERT;
    end else if (r < 95) begin
      return FUNC_CLEAR;
    end
    return FUNC_UNUSED;
  endfunction

  // Result checker: every done pulse must match the oldest pending transaction.
  always @(posedge clk) begin
    outcome_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with no transaction pending");
      end else begin
        e = pending_results.pop_front();
        if (success !== e.ok) begin
          flag_mismatch($sformatf("success %b, expected %b", success, e.ok));
        end
        if (read_value !== e.rd) begin
          flag_mismatch($sformatf("read_value %h, expected %h", read_value, e.rd));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bucketed_pointer_hash_table_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int idle_pct;
    cmd_row_t row;
    logic [FUNC_W-1:0] op;
    for (int i = 0; i < DEPTH; i++) begin
      key_mem[i] = '0;
      val_mem[i] = '0;
    end
    hot_bucket[0] = 8'h00;
    hot_bucket[1] = 8'hFF;
    hot_bucket[2] = 8'($urandom_range(1, 254));
    for (int i = 0; i < POOL_N; i++) begin
      key_pool[i] = fresh_pool_key();
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = dir_rows[i];
      issue_cmd(row.op, row.k, row.v, row.typed, row.ok, row.rd, 0);
    end

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i < RAND_ITEMS / 3) begin
        idle_pct = 13;
      end else if (i < 2 * RAND_ITEMS / 3) begin
        idle_pct = 82;
      end else begin
        idle_pct = 0;
      end
      op = pick_func();
      issue_cmd(op, pick_key(), $urandom, 1'b0, 1'b0, '0, idle_pct);
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (WAYS + 40) @(posedge clk);

    if (err_count == 0) begin
      $display("bucketed_pointer_hash_table_tb: done, clean");
    end else begin
      $display("bucketed_pointer_hash_table_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> bucketed_pointer_hash_table.f
rtl/bpht_pkg.sv
rtl/bpht_ram.sv
rtl/bucketed_pointer_hash_table.sv
tb/bucketed_pointer_hash_table_tb.sv
